// File: hw/rtl/wcs_pkg.sv
// Shared constants and types for the wavelet coefficient shrinkage block.
package wcs_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam logic [1:0] MODE_HARD     = 2'd0;
   localparam logic [1:0] MODE_SOFT     = 2'd1;
   localparam logic [1:0] MODE_SEMISOFT = 2'd2;
   localparam logic [1:0] MODE_SCAD     = 2'd3;
   localparam logic [1:0] RULE_RESET    = MODE_SOFT;

   localparam logic [1:0] KIND_DIRECT = 2'd0;
   localparam logic [1:0] KIND_SQRT   = 2'd1;
   localparam logic [1:0] KIND_DIV    = 2'd2;

   // SCAD with a = 37/10: bands split at 2*lambda and a*lambda.
   localparam int SCAD_BAND_MUL = 2;
   localparam int SCAD_A_NUM    = 37;
   localparam int SCAD_A_DEN    = 10;
   localparam int SCAD_AM1_NUM  = 27;
   localparam int SCAD_AM2_NUM  = 17;
   localparam int DIV_REM_W     = $clog2(SCAD_AM2_NUM);

   typedef struct packed {
      logic       valid;
      logic       neg;
      logic [1:0] kind;
   } wcs_ctl_type;

endpackage

// File: hw/rtl/wcs_if.sv
// Request and response channel interfaces of the wavelet coefficient shrinkage block.
interface wcs_req_if import wcs_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] coefficient;
   logic        [DATA_WIDTH-2:0] threshold;

   modport source (output valid, output coefficient, output threshold, input ready);
   modport sink (input valid, input coefficient, input threshold, output ready);
endinterface

interface wcs_rsp_if import wcs_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] shrunk;

   modport source (output valid, output shrunk, input ready);
   modport sink (input valid, input shrunk, output ready);
endinterface

// File: hw/rtl/wavelet_coefficient_shrinkage.sv
// Top level of the wavelet coefficient shrinkage block.
// Each request carries one signed fixed-point coefficient and its threshold and yields one
// response: zero when the magnitude is below the threshold, otherwise the value shrunk by the
// hard, soft, semisoft or SCAD rule chosen by the two-bit rule register (reset: soft). A new
// request is taken every cycle while the skid register is empty, and each request passes
// through the six front stages, one stage per root bit of the semisoft square root, which
// the SCAD divide by 17 shares, and the response register. A skid register lets the block
// take one more request while a response waits; the rule register may only be written while
// no request is in flight.
module wavelet_coefficient_shrinkage import wcs_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   wcs_req_if.sink    req_ch,
   wcs_rsp_if.source  rsp_ch,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   localparam int MW   = DATA_WIDTH - 1;
   localparam int RADW = 2 * DATA_WIDTH - 2;
   localparam int RW   = DATA_WIDTH + 2;

   logic [1:0] rule_mode_ff;
   logic       en;

   wcs_ctl_type          ctl_pipe  [0:MW];
   logic [RADW-1:0]      rad_pipe  [0:MW];
   logic [RW-1:0]        rem_pipe  [0:MW];
   logic [MW-1:0]        root_pipe [0:MW];
   logic [DIV_REM_W-1:0] drem_pipe [0:MW];

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_mode_ff <= RULE_RESET;
      end else if (csr_wr_en) begin
         rule_mode_ff <= csr_wr_data;
      end
   end

   assign req_ch.ready = en;
   assign rem_pipe[0]  = '0;
   assign drem_pipe[0] = '0;

   wcs_prep #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_prep (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (req_ch.valid),
      .in_coefficient (req_ch.coefficient),
      .in_threshold   (req_ch.threshold),
      .rule_mode      (rule_mode_ff),
      .out_ctl        (ctl_pipe[0]),
      .out_rad        (rad_pipe[0]),
      .out_val        (root_pipe[0])
   );

   for (genvar g = 0; g < MW; g++) begin : g_iter
      wcs_iter_stage #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctl_in   (ctl_pipe[g]),
         .rad_in   (rad_pipe[g]),
         .rem_in   (rem_pipe[g]),
         .root_in  (root_pipe[g]),
         .drem_in  (drem_pipe[g]),
         .ctl_out  (ctl_pipe[g+1]),
         .rad_out  (rad_pipe[g+1]),
         .rem_out  (rem_pipe[g+1]),
         .root_out (root_pipe[g+1]),
         .drem_out (drem_pipe[g+1])
      );
   end

   wcs_out_buf #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .ctl_in     (ctl_pipe[MW]),
      .mag_in     (root_pipe[MW]),
      .en         (en),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_shrunk (rsp_ch.shrunk)
   );

endmodule

// File: hw/rtl/wcs_prep.sv
// Front stages: magnitude, rule selection, SCAD bands and the semisoft radicand product or SCAD dividend.
module wcs_prep import wcs_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [DATA_WIDTH-1:0] in_coefficient,
   input  logic [DATA_WIDTH-2:0] in_threshold,
   input  logic [1:0]            rule_mode,
   output wcs_ctl_type           out_ctl,
   output logic [2*DATA_WIDTH-3:0] out_rad,
   output logic [DATA_WIDTH-2:0] out_val
);

   localparam int W     = DATA_WIDTH;
   localparam int MW    = W - 1;
   localparam int RADW  = 2 * W - 2;
   localparam int H     = W / 2;
   localparam int DHI   = MW - H;
   localparam int SHI   = W - H;
   localparam int P11W  = DHI + SHI;
   localparam int M27W  = W + 4;
   localparam int L37W  = W + 5;
   localparam int M10W  = W + 3;

   // Stage 1: captured request.
   logic          s1_valid_ff;
   logic [W-1:0]  s1_x_ff;
   logic [MW-1:0] s1_lam_ff;

   // Stage 2: saturated magnitude.
   logic          s2_valid_ff, s2_neg_ff;
   logic [MW-1:0] s2_m_ff, s2_lam_ff;
   logic [W-1:0]  abs_x;
   logic [MW-1:0] s2_m_in;

   // Stage 3: sums, differences and scaled terms.
   logic            s3_valid_ff, s3_neg_ff;
   logic [MW-1:0]   s3_m_ff;
   logic [W-1:0]    s3_diff_ff, s3_sum_ff, s3_l2_ff;
   logic [M27W-1:0] s3_m27_ff;
   logic [L37W-1:0] s3_l37_ff;
   logic [M10W-1:0] s3_m10_ff;
   logic [W-1:0]    s3_diff_in, s3_sum_in, s3_l2_in;
   logic [M27W-1:0] s3_m27_in;
   logic [L37W-1:0] s3_l37_in;
   logic [M10W-1:0] s3_m10_in;

   // Stage 4: rule decision and partial products.
   wcs_ctl_type     s4_ctl_ff, s4_ctl_in;
   logic [MW-1:0]   s4_val_ff, s4_val_in;
   logic [M27W-1:0] s4_num_ff, s4_num_in;
   logic [2*H-1:0]  s4_p00_ff, s4_p00_in;
   logic [W-1:0]    s4_p01_ff, s4_p01_in;
   logic [MW-1:0]   s4_p10_ff, s4_p10_in;
   logic [P11W-1:0] s4_p11_ff, s4_p11_in;
   logic [L37W-1:0] num_wide;
   logic            below;

   // Stage 5: middle partial products summed.
   wcs_ctl_type     s5_ctl_ff;
   logic [MW-1:0]   s5_val_ff;
   logic [M27W-1:0] s5_num_ff;
   logic [2*H-1:0]  s5_p00_ff;
   logic [W:0]      s5_mid_ff, s5_mid_in;
   logic [P11W-1:0] s5_p11_ff;

   // Stage 6: radicand or dividend.
   wcs_ctl_type     s6_ctl_ff;
   logic [MW-1:0]   s6_val_ff;
   logic [RADW-1:0] s6_rad_ff, s6_rad_in;

   assign abs_x   = s1_x_ff[W-1] ? (~s1_x_ff + W'(1)) : s1_x_ff;
   assign s2_m_in = abs_x[W-1] ? {MW{1'b1}} : abs_x[MW-1:0];

   assign s3_diff_in = {1'b0, s2_m_ff} - {1'b0, s2_lam_ff};
   assign s3_sum_in  = {1'b0, s2_m_ff} + {1'b0, s2_lam_ff};
   assign s3_l2_in   = W'(s2_lam_ff) * W'(SCAD_BAND_MUL);
   assign s3_m27_in  = M27W'(s2_m_ff) * M27W'(SCAD_AM1_NUM);
   assign s3_l37_in  = L37W'(s2_lam_ff) * L37W'(SCAD_A_NUM);
   assign s3_m10_in  = M10W'(s2_m_ff) * M10W'(SCAD_A_DEN);

   assign below     = s3_diff_ff[W-1];
   assign num_wide  = L37W'(s3_m27_ff) - s3_l37_ff;
   assign s4_num_in = num_wide[M27W-1:0];
   assign s4_p00_in = (2*H)'(s3_diff_ff[H-1:0]) * (2*H)'(s3_sum_ff[H-1:0]);
   assign s4_p01_in = W'(s3_diff_ff[H-1:0]) * W'(s3_sum_ff[W-1:H]);
   assign s4_p10_in = MW'(s3_diff_ff[MW-1:H]) * MW'(s3_sum_ff[H-1:0]);
   assign s4_p11_in = P11W'(s3_diff_ff[MW-1:H]) * P11W'(s3_sum_ff[W-1:H]);

   always_comb begin
      s4_ctl_in.valid = s3_valid_ff;
      s4_ctl_in.neg   = s3_neg_ff;
      s4_ctl_in.kind  = KIND_DIRECT;
      s4_val_in       = '0;
      if (!below) begin
         case (rule_mode)
            MODE_HARD: begin
               s4_val_in = s3_m_ff;
            end
            MODE_SOFT: begin
               s4_val_in = s3_diff_ff[MW-1:0];
            end
            MODE_SEMISOFT: begin
               s4_ctl_in.kind = KIND_SQRT;
            end
            MODE_SCAD: begin
               if (W'(s3_m_ff) <= s3_l2_ff) begin
                  s4_val_in = s3_diff_ff[MW-1:0];
               end else if (L37W'(s3_m10_ff) <= s3_l37_ff) begin
                  s4_ctl_in.kind = KIND_DIV;
               end else begin
                  s4_val_in = s3_m_ff;
               end
            end
            default: begin
               s4_val_in = s3_m_ff;
            end
         endcase
      end
   end

   assign s5_mid_in = (W+1)'(s4_p01_ff) + (W+1)'(s4_p10_ff);

   always_comb begin
      if (s5_ctl_ff.kind == KIND_SQRT) begin
         s6_rad_in = RADW'({s5_p11_ff, s5_p00_ff}) + RADW'({s5_mid_ff, {H{1'b0}}});
      end else begin
         s6_rad_in = RADW'(s5_num_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_ctl_ff   <= '0;
         s5_ctl_ff   <= '0;
         s6_ctl_ff   <= '0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_ctl_ff   <= s4_ctl_in;
         s5_ctl_ff   <= s4_ctl_ff;
         s6_ctl_ff   <= s5_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff         <= in_coefficient;
         s1_lam_ff       <= in_threshold;
         s2_neg_ff       <= s1_x_ff[W-1];
         s2_m_ff         <= s2_m_in;
         s2_lam_ff       <= s1_lam_ff;
         s3_neg_ff       <= s2_neg_ff;
         s3_m_ff         <= s2_m_ff;
         s3_diff_ff      <= s3_diff_in;
         s3_sum_ff       <= s3_sum_in;
         s3_l2_ff        <= s3_l2_in;
         s3_m27_ff       <= s3_m27_in;
         s3_l37_ff       <= s3_l37_in;
         s3_m10_ff       <= s3_m10_in;
         s4_val_ff       <= s4_val_in;
         s4_num_ff       <= s4_num_in;
         s4_p00_ff       <= s4_p00_in;
         s4_p01_ff       <= s4_p01_in;
         s4_p10_ff       <= s4_p10_in;
         s4_p11_ff       <= s4_p11_in;
         s5_val_ff       <= s4_val_ff;
         s5_num_ff       <= s4_num_ff;
         s5_p00_ff       <= s4_p00_ff;
         s5_mid_ff       <= s5_mid_in;
         s5_p11_ff       <= s4_p11_ff;
         s6_val_ff       <= s5_val_ff;
         s6_rad_ff       <= s6_rad_in;
      end
   end

   assign out_ctl = s6_ctl_ff;
   assign out_rad = s6_rad_ff;
   assign out_val = s6_val_ff;

endmodule

// File: hw/rtl/wcs_iter_stage.sv
// One pipeline step: a square root bit or two quotient bits of the divide by 17, or a direct value passed on.
module wcs_iter_stage import wcs_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  wcs_ctl_type            ctl_in,
   input  logic [2*DATA_WIDTH-3:0] rad_in,
   input  logic [DATA_WIDTH+1:0]  rem_in,
   input  logic [DATA_WIDTH-2:0]  root_in,
   input  logic [DIV_REM_W-1:0]   drem_in,
   output wcs_ctl_type            ctl_out,
   output logic [2*DATA_WIDTH-3:0] rad_out,
   output logic [DATA_WIDTH+1:0]  rem_out,
   output logic [DATA_WIDTH-2:0]  root_out,
   output logic [DIV_REM_W-1:0]   drem_out
);

   localparam int MW   = DATA_WIDTH - 1;
   localparam int RADW = 2 * DATA_WIDTH - 2;
   localparam int RW   = DATA_WIDTH + 2;
   localparam int TW   = DIV_REM_W + 1;

   wcs_ctl_type          ctl_ff;
   logic [RADW-1:0]      rad_ff, rad_step_in;
   logic [RW-1:0]        rem_ff, rem_step_in;
   logic [MW-1:0]        root_ff, root_step_in;
   logic [DIV_REM_W-1:0] drem_ff, drem_step_in;

   logic [1:0]           pair;
   logic [RW-1:0]        rem_sh, trial;
   logic                 root_bit;
   logic [TW-1:0]        t1, t2;
   logic                 q1, q2;
   logic [DIV_REM_W-1:0] d1, d2;

   assign pair        = rad_in[RADW-1 -: 2];
   assign rad_step_in = {rad_in[RADW-3:0], 2'b00};

   assign rem_sh   = {rem_in[RW-3:0], pair};
   assign trial    = RW'({root_in, 2'b01});
   assign root_bit = rem_sh >= trial;

   assign t1 = {drem_in, pair[1]};
   assign q1 = t1 >= TW'(SCAD_AM2_NUM);
   assign d1 = q1 ? DIV_REM_W'(t1 - TW'(SCAD_AM2_NUM)) : t1[DIV_REM_W-1:0];
   assign t2 = {d1, pair[0]};
   assign q2 = t2 >= TW'(SCAD_AM2_NUM);
   assign d2 = q2 ? DIV_REM_W'(t2 - TW'(SCAD_AM2_NUM)) : t2[DIV_REM_W-1:0];

   always_comb begin
      rem_step_in  = rem_in;
      root_step_in = root_in;
      drem_step_in = drem_in;
      case (ctl_in.kind)
         KIND_SQRT: begin
            rem_step_in  = root_bit ? (rem_sh - trial) : rem_sh;
            root_step_in = {root_in[MW-2:0], root_bit};
         end
         KIND_DIV: begin
            drem_step_in = d2;
            root_step_in = {root_in[MW-3:0], q1, q2};
         end
         default: begin
            root_step_in = root_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_step_in;
         rem_ff  <= rem_step_in;
         root_ff <= root_step_in;
         drem_ff <= drem_step_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign drem_out = drem_ff;

endmodule

// File: hw/rtl/wcs_out_buf.sv
// Sign restore, response register and skid register that decouples the pipeline from the sink.
module wcs_out_buf import wcs_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wcs_ctl_type           ctl_in,
   input  logic [DATA_WIDTH-2:0] mag_in,
   output logic                  en,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_shrunk
);

   localparam int W = DATA_WIDTH;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_data_ff, rsp_data_in;
   logic         skid_valid_ff, skid_valid_in;
   logic [W-1:0] skid_data_ff, skid_data_in;
   logic [W-1:0] value;
   logic         take, incoming;

   assign value    = ctl_in.neg ? (W'(0) - {1'b0, mag_in}) : {1'b0, mag_in};
   assign en       = !skid_valid_ff;
   assign take     = rsp_valid_ff && rsp_ready;
   assign incoming = en && ctl_in.valid;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (incoming) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = value;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = value;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_shrunk = rsp_data_ff;

endmodule

// File: hw/rtl/wcs_checker.sv
// Port-level assertions for the wavelet coefficient shrinkage block, bound to its top level.
module wcs_checker import wcs_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_shrunk
);

   localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // The block only pushes back on requests while a response is waiting.
   assert property (@(posedge clock) disable iff (reset) req_valid && !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   // A saturated magnitude can never come out as the most negative code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shrunk != MOST_NEG)
      else $error("response holds the most negative code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_shrunk))
      else $error("stalled response changed");

   // Back-pressure lifts only after the sink takes a response.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready && !rsp_ready |=> !req_ready)
      else $error("request side reopened without a response taken");

   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("reset did not clear the response side");

endmodule

bind wavelet_coefficient_shrinkage wcs_checker #(
   .DATA_WIDTH(DATA_WIDTH)
) u_wcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_shrunk (rsp_ch.shrunk)
);
